@@ rtl/nta_pkg.sv @@
// nta_pkg: shared types and constants of the neighbor table aging unit
// no dependencies; used by nta_ctrl, nta_datapath and neighbor_table_aging_unit
`default_nettype none

package nta_pkg;

    // operation codes carried in the func field of a request
    localparam logic [1:0] FUNC_REPORT = 2'd0;
    localparam logic [1:0] FUNC_ADVERT = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_QUERY  = 2'd3;

    // reset value of the idle limit register
    localparam logic [15:0] MAX_IDLE_RESET = 16'd100;

    // request payload
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] neighbor_id;
        logic [15:0] adv_offset;
    } t_nta_req;

    // response payload
    typedef struct packed {
        logic [15:0] slots_since_seen;
        logic        was_new;
        logic [4:0]  active_count;
        logic        offset_valid;
        logic [15:0] next_offset;
        logic        table_full;
    } t_nta_rsp;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EXEC
    } t_nta_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
    } t_nta_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_nta_sts;

endpackage

`default_nettype wire

@@ rtl/nta_ctrl.sv @@
// nta_ctrl: sequencing state machine of the neighbor table aging unit
// depends on nta_pkg; drives commands into nta_datapath
`default_nettype none

module nta_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire nta_pkg::t_nta_sts i_sts,
    output nta_pkg::t_nta_cmd      o_cmd
);

    nta_pkg::t_nta_state r_state;
    nta_pkg::t_nta_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nta_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nta_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = nta_pkg::ST_SCAN;
            end
            nta_pkg::ST_SCAN: begin
                if (i_sts.scan_last) n_state = nta_pkg::ST_DRAIN;
            end
            nta_pkg::ST_DRAIN: begin
                n_state = nta_pkg::ST_EXEC;
            end
            nta_pkg::ST_EXEC: begin
                if (i_sts.out_free) n_state = nta_pkg::ST_IDLE;
            end
            default: begin
                n_state = nta_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            nta_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            nta_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            nta_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            nta_pkg::ST_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/nta_datapath.sv @@
// nta_datapath: entry memory, valid bits, scan logic and response register
// depends on nta_pkg; controlled by nta_ctrl through t_nta_cmd / t_nta_sts
`default_nettype none

module nta_datapath #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire             [15:0] i_cfg_data,
    input  wire nta_pkg::t_nta_req i_req,
    input  wire nta_pkg::t_nta_cmd i_cmd,
    output nta_pkg::t_nta_sts      o_sts,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output nta_pkg::t_nta_rsp      o_rsp
);

    localparam int IW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AW      = $clog2(TABLE_ENTRIES + 1);
    localparam int CNT_LSB = 16;
    localparam int KEY_LSB = 16 + COUNT_BITS;
    localparam int WW      = 48 + COUNT_BITS;
    localparam logic [IW-1:0]         LAST_IDX = IW'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};

    // entry memory word: {key, idle count, offset}
    logic [WW-1:0] r_mem [TABLE_ENTRIES];

    logic [15:0]              r_max_idle;
    nta_pkg::t_nta_req        r_req,      n_req;
    logic [IW-1:0]            r_idx,      n_idx;
    logic [IW-1:0]            r_rd_idx;
    logic                     r_rd_vld;
    logic [WW-1:0]            r_rd_data;
    logic [TABLE_ENTRIES-1:0] r_active,   n_active;
    logic [TABLE_ENTRIES-1:0] r_ovalid,   n_ovalid;
    logic [AW-1:0]            r_total,    n_total;
    logic                     r_found,    n_found;
    logic [IW-1:0]            r_m_idx,    n_m_idx;
    logic [COUNT_BITS-1:0]    r_m_cnt,    n_m_cnt;
    logic [15:0]              r_m_off,    n_m_off;
    logic                     r_free,     n_free;
    logic [IW-1:0]            r_f_idx,    n_f_idx;
    logic                     r_out_vld,  n_out_vld;
    nta_pkg::t_nta_rsp        r_rsp,      n_rsp;

    logic                     n_we;
    logic [IW-1:0]            n_wa;
    logic [WW-1:0]            n_wd;

    // fields of the entry read during the scan
    logic [31:0]           d_key;
    logic [COUNT_BITS-1:0] d_cnt;
    logic [15:0]           d_off;
    logic                  rd_active;
    logic                  rd_ovalid;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  evict;
    logic [31:0]           m_cnt_ext;
    logic [15:0]           m_seen;

    assign d_key     = r_rd_data[KEY_LSB +: 32];
    assign d_cnt     = r_rd_data[CNT_LSB +: COUNT_BITS];
    assign d_off     = r_rd_data[15:0];
    assign rd_active = r_active[r_rd_idx];
    assign rd_ovalid = r_ovalid[r_rd_idx];

    // aging: saturating increment, then compare against the limit
    assign cnt_inc = (d_cnt == CNT_MAX) ? d_cnt : d_cnt + COUNT_BITS'(1);
    assign evict   = 32'(cnt_inc) >= 32'(r_max_idle);

    // reported count clamps to the 16-bit field
    assign m_cnt_ext = 32'(r_m_cnt);
    assign m_seen    = (m_cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : m_cnt_ext[15:0];

    assign o_sts.scan_last = (r_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;
    assign o_out_valid     = r_out_vld;
    assign o_rsp           = r_rsp;

    // scan, tick update and request execution
    always_comb begin
        nta_pkg::t_nta_rsp rsp;
        rsp       = '0;
        n_req     = r_req;
        n_idx     = r_idx;
        n_active  = r_active;
        n_ovalid  = r_ovalid;
        n_total   = r_total;
        n_found   = r_found;
        n_m_idx   = r_m_idx;
        n_m_cnt   = r_m_cnt;
        n_m_off   = r_m_off;
        n_free    = r_free;
        n_f_idx   = r_f_idx;
        n_out_vld = r_out_vld && i_out_stall;
        n_rsp     = r_rsp;
        n_we      = 1'b0;
        n_wa      = r_rd_idx;
        n_wd      = r_rd_data;

        // new request
        if (i_cmd.load) begin
            n_req   = i_req;
            n_idx   = '0;
            n_found = 1'b0;
            n_free  = 1'b0;
        end

        // read address walks the table
        if (i_cmd.scan) begin
            n_idx = r_idx + IW'(1);
        end

        // one entry of read data per cycle
        if (r_rd_vld) begin
            if (r_req.func == nta_pkg::FUNC_TICK) begin
                if (rd_active) begin
                    n_we = 1'b1;
                    n_wa = r_rd_idx;
                    n_wd = {d_key, cnt_inc,
                            (rd_ovalid && d_off != 16'd0) ? d_off - 16'd1 : d_off};
                    if (rd_ovalid && d_off == 16'd0) n_ovalid[r_rd_idx] = 1'b0;
                    if (evict) begin
                        n_active[r_rd_idx] = 1'b0;
                        n_ovalid[r_rd_idx] = 1'b0;
                        n_total            = r_total - AW'(1);
                    end
                end
            end else begin
                if ((rd_active || rd_ovalid) && d_key == r_req.neighbor_id && !r_found) begin
                    n_found = 1'b1;
                    n_m_idx = r_rd_idx;
                    n_m_cnt = d_cnt;
                    n_m_off = d_off;
                end
                if (!(rd_active || rd_ovalid) && !r_free) begin
                    n_free  = 1'b1;
                    n_f_idx = r_rd_idx;
                end
            end
        end

        // apply the operation and load the response register
        if (i_cmd.exec) begin
            case (r_req.func)
                nta_pkg::FUNC_REPORT: begin
                    if (r_found && r_active[r_m_idx]) begin
                        rsp.slots_since_seen = m_seen;
                        rsp.offset_valid     = r_ovalid[r_m_idx];
                        rsp.next_offset      = r_ovalid[r_m_idx] ? r_m_off : 16'd0;
                        n_we = 1'b1;
                        n_wa = r_m_idx;
                        n_wd = {r_req.neighbor_id, {COUNT_BITS{1'b0}}, r_m_off};
                    end else if (r_found) begin
                        // entry held only an offset
                        n_active[r_m_idx] = 1'b1;
                        n_total           = r_total + AW'(1);
                        rsp.was_new       = 1'b1;
                        rsp.offset_valid  = 1'b1;
                        rsp.next_offset   = r_m_off;
                        n_we = 1'b1;
                        n_wa = r_m_idx;
                        n_wd = {r_req.neighbor_id, {COUNT_BITS{1'b0}}, r_m_off};
                    end else if (r_free) begin
                        n_active[r_f_idx] = 1'b1;
                        n_ovalid[r_f_idx] = 1'b0;
                        n_total           = r_total + AW'(1);
                        rsp.was_new       = 1'b1;
                        n_we = 1'b1;
                        n_wa = r_f_idx;
                        n_wd = {r_req.neighbor_id, {COUNT_BITS{1'b0}}, 16'd0};
                    end else begin
                        rsp.table_full = 1'b1;
                    end
                end
                nta_pkg::FUNC_ADVERT: begin
                    if (r_found) begin
                        n_ovalid[r_m_idx] = 1'b1;
                        rsp.offset_valid  = 1'b1;
                        rsp.next_offset   = r_req.adv_offset;
                        n_we = 1'b1;
                        n_wa = r_m_idx;
                        n_wd = {r_req.neighbor_id, r_m_cnt, r_req.adv_offset};
                    end else if (r_free) begin
                        n_active[r_f_idx] = 1'b0;
                        n_ovalid[r_f_idx] = 1'b1;
                        rsp.offset_valid  = 1'b1;
                        rsp.next_offset   = r_req.adv_offset;
                        n_we = 1'b1;
                        n_wa = r_f_idx;
                        n_wd = {r_req.neighbor_id, {COUNT_BITS{1'b0}}, r_req.adv_offset};
                    end else begin
                        rsp.table_full = 1'b1;
                    end
                end
                nta_pkg::FUNC_QUERY: begin
                    if (r_found) begin
                        rsp.slots_since_seen = r_active[r_m_idx] ? m_seen : 16'd0;
                        rsp.offset_valid     = r_ovalid[r_m_idx];
                        rsp.next_offset      = r_ovalid[r_m_idx] ? r_m_off : 16'd0;
                    end
                end
                default: begin
                    // tick: table already aged during the scan
                    rsp.table_full = 1'b0;
                end
            endcase
            rsp.active_count = 5'(n_total);
            n_rsp            = rsp;
            n_out_vld        = 1'b1;
        end
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_wa] <= n_wd;
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_idle <= nta_pkg::MAX_IDLE_RESET;
            r_active   <= '0;
            r_ovalid   <= '0;
            r_total    <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_idle <= i_cfg_data;
            r_active  <= n_active;
            r_ovalid  <= n_ovalid;
            r_total   <= n_total;
            r_rd_vld  <= i_cmd.scan;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_idx    <= n_idx;
        r_rd_idx <= r_idx;
        r_found  <= n_found;
        r_m_idx  <= n_m_idx;
        r_m_cnt  <= n_m_cnt;
        r_m_off  <= n_m_off;
        r_free   <= n_free;
        r_f_idx  <= n_f_idx;
        r_rsp    <= n_rsp;
    end

endmodule

`default_nettype wire

@@ rtl/neighbor_table_aging_unit.sv @@
// neighbor_table_aging_unit: top level of the neighbor table with aging
// depends on nta_pkg, nta_ctrl and nta_datapath
`default_nettype none

// Neighbor table of TABLE_ENTRIES entries keyed by a 32-bit neighbor id. Each
// request is an activity report, a broadcast advertisement, a slot-end tick or
// a query, and yields exactly one response. Every request walks the entry
// memory one entry per cycle through its single read port: the tick ages each
// active entry on the way, the other requests locate the id and the first
// free entry and are applied in a final cycle. After acceptance a request
// holds the unit through the scan, a drain and an execute state that waits
// for the response register to be free; a finished response may wait in its
// register while the next request is accepted. max_idle_slots is written
// through i_cfg_we / i_cfg_data, by the user only while idle (unenforced).

module neighbor_table_aging_unit #(
    parameter int TABLE_ENTRIES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire             [15:0] i_cfg_data,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire nta_pkg::t_nta_req i_req,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output nta_pkg::t_nta_rsp      o_rsp
);

    nta_pkg::t_nta_cmd cmd;
    nta_pkg::t_nta_sts sts;

    // sequencing
    nta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table storage and execution
    nta_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for neighbor_table_aging_unit, with its own table predictor
// depends on nta_pkg and the rtl of neighbor_table_aging_unit

module testbench;

    localparam int TABLE_ENTRIES  = 16;
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 3 + 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int POOL_SIZE      = 20;
    localparam logic [31:0] ID_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [31:0] ID_ZERO     = 32'h0000_0000;

    // dut connections; the ones driven by the bench are known from time zero
    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     [15:0] cfg_data = '0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    nta_pkg::t_nta_req req = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    nta_pkg::t_nta_rsp rsp;

    // predictor copy of the table and of the idle limit
    logic [31:0] tbl_key    [TABLE_ENTRIES] = '{default: '0};
    bit          tbl_active [TABLE_ENTRIES];
    logic [15:0] tbl_idle   [TABLE_ENTRIES] = '{default: '0};
    bit          tbl_off_valid [TABLE_ENTRIES];
    logic [15:0] tbl_offset [TABLE_ENTRIES] = '{default: '0};
    int unsigned active_total = 0;
    logic [15:0] idle_limit   = nta_pkg::MAX_IDLE_RESET;

    nta_pkg::t_nta_rsp predicted_rsps[$];
    logic [31:0] id_pool [POOL_SIZE];
    int          mismatches   = 0;
    int          rsp_count    = 0;
    bit          idle_on      = 1'b1;
    bit          hold_off_req = 1'b0;
    int          hold_left    = 0;
    int          burst_left   = 0;
    int          quiet_cycles = 0;

    neighbor_table_aging_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req       (req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_rsp       (rsp)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // first entry holding neither activity nor an offset
    function automatic int first_unused();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_active[i] && !tbl_off_valid[i]) return i;
        end
        return -1;
    endfunction

    // apply one request to the predicted table and return its response
    function automatic nta_pkg::t_nta_rsp apply_table_op(input nta_pkg::t_nta_req r);
        nta_pkg::t_nta_rsp p;
        int       slot;
        p    = '0;
        slot = -1;
        if (r.func == nta_pkg::FUNC_TICK) begin
            // age active entries, run down offsets, evict at the limit
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_active[i]) begin
                    if (tbl_idle[i] != 16'hFFFF) tbl_idle[i]++;
                    if (tbl_off_valid[i]) begin
                        if (tbl_offset[i] != 16'd0) tbl_offset[i]--;
                        else tbl_off_valid[i] = 1'b0;
                    end
                    if (tbl_idle[i] >= idle_limit) begin
                        tbl_active[i]    = 1'b0;
                        tbl_off_valid[i] = 1'b0;
                        active_total--;
                    end
                end
            end
        end else begin
            // lookup among entries in use
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && (tbl_active[i] || tbl_off_valid[i]) &&
                    tbl_key[i] == r.neighbor_id) slot = i;
            end
            case (r.func)
                nta_pkg::FUNC_REPORT: begin
                    if (slot >= 0 && tbl_active[slot]) begin
                        p.slots_since_seen = tbl_idle[slot];
                        tbl_idle[slot] = '0;
                    end else begin
                        if (slot < 0) begin
                            slot = first_unused();
                            if (slot >= 0) begin
                                tbl_key[slot]       = r.neighbor_id;
                                tbl_off_valid[slot] = 1'b0;
                            end
                        end
                        if (slot < 0) begin
                            p.table_full = 1'b1;
                        end else begin
                            tbl_active[slot] = 1'b1;
                            tbl_idle[slot]   = '0;
                            active_total++;
                            p.was_new = 1'b1;
                        end
                    end
                end
                nta_pkg::FUNC_ADVERT: begin
                    if (slot < 0) begin
                        slot = first_unused();
                        if (slot >= 0) begin
                            tbl_key[slot]    = r.neighbor_id;
                            tbl_active[slot] = 1'b0;
                        end
                    end
                    if (slot < 0) begin
                        p.table_full = 1'b1;
                    end else begin
                        tbl_offset[slot]    = r.adv_offset;
                        tbl_off_valid[slot] = 1'b1;
                    end
                end
                nta_pkg::FUNC_QUERY: begin
                    if (slot >= 0 && tbl_active[slot]) p.slots_since_seen = tbl_idle[slot];
                end
                default: ;
            endcase
        end
        p.active_count = 5'(active_total);
        if (slot >= 0 && tbl_off_valid[slot]) begin
            p.offset_valid = 1'b1;
            p.next_offset  = tbl_offset[slot];
        end
        return p;
    endfunction

    // random request, mostly on a small pool of ids so that entries get reused
    function automatic nta_pkg::t_nta_req random_req();
        nta_pkg::t_nta_req r;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) r.func = nta_pkg::FUNC_REPORT;
        else if (pick < 55) r.func = nta_pkg::FUNC_ADVERT;
        else if (pick < 85) r.func = nta_pkg::FUNC_TICK;
        else r.func = nta_pkg::FUNC_QUERY;
        r.neighbor_id = ($urandom_range(0, 9) == 0) ? 32'($urandom)
                                                    : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        r.adv_offset = $urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom);
        return r;
    endfunction

    // send one request; valid stays high after acceptance until the caller lowers it
    task automatic send_req(input nta_pkg::t_nta_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req      <= r;
        do @(posedge clk); while (in_stall !== 1'b0);
        predicted_rsps = {predicted_rsps, apply_table_op(r)};
    endtask

    task automatic send_op(input logic [1:0] f, input logic [31:0] id,
                           input logic [15:0] offs);
        nta_pkg::t_nta_req r;
        r.func        = f;
        r.neighbor_id = id;
        r.adv_offset  = offs;
        send_req(r);
    endtask

    // stop offering and wait until every response is back
    task automatic drain_rsps();
        in_valid <= 1'b0;
        do @(posedge clk); while (predicted_rsps.size() != 0);
    endtask

    // idle limit write, only with the unit idle
    task automatic write_idle_limit(input logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        idle_limit = value;
    endtask

    // reset limit: insert, advertise, age, read back, clear, miss
    task automatic test_report_and_query();
        send_op(nta_pkg::FUNC_REPORT, ID_ALL_ONES, 16'hFFFF);
        send_op(nta_pkg::FUNC_ADVERT, ID_ALL_ONES, 16'hFFFF);
        send_op(nta_pkg::FUNC_TICK, $urandom, 16'($urandom));
        send_op(nta_pkg::FUNC_QUERY, ID_ALL_ONES, 16'h0000);
        send_op(nta_pkg::FUNC_REPORT, ID_ALL_ONES, 16'h0000);
        send_op(nta_pkg::FUNC_QUERY, ID_ZERO, 16'hFFFF);
        drain_rsps();
    endtask

    // offset held by an inactive id is not aged until the id turns active
    task automatic test_offset_without_activity();
        send_op(nta_pkg::FUNC_ADVERT, ID_ZERO, 16'd1);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_QUERY, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_REPORT, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_QUERY, ID_ZERO, 16'd0);
        drain_rsps();
    endtask

    // fill every entry, then an insert and an advertisement must be dropped
    task automatic test_table_full();
        for (int i = 0; i < TABLE_ENTRIES - 2; i++) begin
            send_op(nta_pkg::FUNC_REPORT, {16'hA5A5, 16'(i)}, 16'($urandom));
        end
        send_op(nta_pkg::FUNC_REPORT, 32'h1234_5678, 16'd0);
        send_op(nta_pkg::FUNC_ADVERT, 32'h1234_5678, 16'h8000);
        drain_rsps();
    endtask

    // limit of one evicts the whole table, zero evicts at the next tick, top value keeps it
    task automatic test_idle_limits();
        write_idle_limit(16'd1);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_QUERY, ID_ALL_ONES, 16'd0);
        drain_rsps();
        write_idle_limit(16'd0);
        send_op(nta_pkg::FUNC_REPORT, 32'h5A5A_5A5A, 16'd0);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_QUERY, 32'h5A5A_5A5A, 16'd0);
        drain_rsps();
        write_idle_limit(16'hFFFF);
        send_op(nta_pkg::FUNC_REPORT, 32'h5A5A_5A5A, 16'd0);
        send_op(nta_pkg::FUNC_TICK, ID_ZERO, 16'd0);
        send_op(nta_pkg::FUNC_QUERY, 32'h5A5A_5A5A, 16'd0);
        drain_rsps();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        foreach (id_pool[k]) id_pool[k] = $urandom;
        hold_off_req = 1'b1;
        repeat (12) send_req(random_req());
        drain_rsps();
    endtask

    // random traffic over several idle limits, idling switched on and off
    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++) begin
            foreach (id_pool[k]) id_pool[k] = $urandom;
            case (phase)
                0: write_idle_limit(nta_pkg::MAX_IDLE_RESET);
                1: write_idle_limit(16'($urandom_range(2, 10)));
                2: write_idle_limit(16'hFFFF);
                3: write_idle_limit(16'($urandom_range(11, 40)));
                default: write_idle_limit(16'd1);
            endcase
            for (int n = 0; n < 260; n++) begin
                if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
                send_req(random_req());
            end
            drain_rsps();
        end
    endtask

    // last stretch at full rate on both sides
    task automatic test_steady_stream();
        idle_on = 1'b0;
        foreach (id_pool[k]) id_pool[k] = $urandom;
        write_idle_limit(16'($urandom_range(3, 8)));
        repeat (100) send_req(random_req());
        drain_rsps();
    endtask

    // receiver stall: long hold-off on request, else random bursts while idling is on
    always @(posedge clk) begin
        if (hold_off_req) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (idle_on && burst_left > 0) begin
            burst_left--;
            out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // compare each accepted response with the oldest prediction
    always @(posedge clk) begin : check_rsp
        nta_pkg::t_nta_rsp want;
        if (out_valid === 1'b1 && out_stall === 1'b0) begin
            rsp_count++;
            if (predicted_rsps.size() == 0) begin
                report_mismatch($sformatf("response %0d with none expected", rsp_count));
            end else begin
                want = predicted_rsps.pop_front();
                if (rsp.slots_since_seen !== want.slots_since_seen)
                    report_mismatch($sformatf("rsp %0d slots_since_seen %h, want %h",
                        rsp_count, rsp.slots_since_seen, want.slots_since_seen));
                if (rsp.was_new !== want.was_new)
                    report_mismatch($sformatf("rsp %0d was_new %b, want %b",
                        rsp_count, rsp.was_new, want.was_new));
                if (rsp.active_count !== want.active_count)
                    report_mismatch($sformatf("rsp %0d active_count %0d, want %0d",
                        rsp_count, rsp.active_count, want.active_count));
                if (rsp.offset_valid !== want.offset_valid)
                    report_mismatch($sformatf("rsp %0d offset_valid %b, want %b",
                        rsp_count, rsp.offset_valid, want.offset_valid));
                if (rsp.next_offset !== want.next_offset)
                    report_mismatch($sformatf("rsp %0d next_offset %h, want %h",
                        rsp_count, rsp.next_offset, want.next_offset));
                if (rsp.table_full !== want.table_full)
                    report_mismatch($sformatf("rsp %0d table_full %b, want %b",
                        rsp_count, rsp.table_full, want.table_full));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_report_and_query();
        test_offset_without_activity();
        test_table_full();
        test_idle_limits();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
